>>> sv/dlt_pkg.sv
// Shared definitions for the directory listing tokenizer.
// Holds the default limits, the character codes and the result record type.
// No dependencies.
package dlt_pkg;

	localparam int DltMaxEntries = 64;
	localparam int DltNameMaxLen = 255;

	localparam int IDX_W   = 6;
	localparam int POS_W   = 8;
	localparam int CHAR_W  = 8;
	localparam int LEN_W   = 8;
	localparam int COUNT_W = 7;

	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;

	typedef struct packed {
		logic               char_valid;
		logic [IDX_W-1:0]   entry_index;
		logic [POS_W-1:0]   char_pos;
		logic [CHAR_W-1:0]  char_value;
		logic               entry_done;
		logic [LEN_W-1:0]   entry_len;
		logic               entry_is_dir;
		logic               list_done;
		logic [COUNT_W-1:0] entry_count;
	} dlt_result_t;

endpackage

>>> sv/dlt_parser.sv
// Tokenizer state and per-byte decision logic.
// Updates the parse state on each transfer and forms the result record for that byte.
// Depends on dlt_pkg.
module dlt_parser #(
	parameter int MAX_ENTRIES  = dlt_pkg::DltMaxEntries,
	parameter int NAME_MAX_LEN = dlt_pkg::DltNameMaxLen
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [dlt_pkg::CHAR_W-1:0]  ch,
	output dlt_pkg::dlt_result_t        res
);
	import dlt_pkg::*;

	localparam int CW = $clog2(NAME_MAX_LEN + 2);
	localparam int AW = $clog2(MAX_ENTRIES + 1);

	logic              at_list_start_q;
	logic              list_rejected_q;
	logic              in_token_q;
	logic [CW-1:0]     cap_q;
	logic [CHAR_W-1:0] pend_q;
	logic [AW-1:0]     acc_q;

	logic          rej;
	logic          active;
	logic          is_zero;
	logic          is_sep;
	logic          finish;
	logic          grow;
	logic          room;
	logic          is_dir;
	logic          acc_inc;
	logic [CW-1:0] last;
	logic [CW-1:0] len_raw;
	logic [CW-1:0] len_clip;
	logic [CW-1:0] cap_eff;
	logic [AW-1:0] acc_nxt;

	always_comb begin
		res = '0;
		rej = at_list_start_q ? (ch == CH_LPAREN) : list_rejected_q;
		active = !rej && (acc_q < AW'(MAX_ENTRIES));
		is_zero = (ch == CH_NUL);
		is_sep = ch inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
		finish = active && in_token_q && (is_zero || is_sep);
		grow = active && !is_zero && !is_sep;
		is_dir = (pend_q == CH_SLASH);
		last = cap_q - CW'(1);
		len_raw = cap_q - CW'(is_dir);
		len_clip = (len_raw > CW'(NAME_MAX_LEN)) ? CW'(NAME_MAX_LEN) : len_raw;
		cap_eff = in_token_q ? cap_q : '0;
		room = (cap_eff < CW'(NAME_MAX_LEN + 1));
		acc_inc = finish && (len_clip != '0);
		acc_nxt = acc_q + AW'(acc_inc);

		// The held byte goes out once the next byte or the token end shows what it is.
		if (finish) begin
			if (!is_dir && (last < CW'(NAME_MAX_LEN))) begin
				res.char_valid = 1'b1;
				res.entry_index = IDX_W'(acc_q);
				res.char_pos = POS_W'(last);
				res.char_value = pend_q;
			end
			if (acc_inc) begin
				res.entry_index = IDX_W'(acc_q);
				res.entry_done = 1'b1;
				res.entry_len = LEN_W'(len_clip);
				res.entry_is_dir = is_dir;
			end
		end
		if (grow && room && (cap_eff != '0)) begin
			res.char_valid = 1'b1;
			res.entry_index = IDX_W'(acc_q);
			res.char_pos = POS_W'(cap_eff - CW'(1));
			res.char_value = pend_q;
		end
		res.list_done = is_zero;
		res.entry_count = rej ? '0 : COUNT_W'(acc_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_list_start_q <= 1'b1;
			list_rejected_q <= 1'b0;
			in_token_q <= 1'b0;
			cap_q <= '0;
			acc_q <= '0;
		end else if (accept) begin
			at_list_start_q <= is_zero;
			list_rejected_q <= is_zero ? 1'b0 : rej;
			acc_q <= is_zero ? '0 : acc_nxt;
			if (is_zero || finish) begin
				in_token_q <= 1'b0;
				cap_q <= '0;
			end else if (grow) begin
				in_token_q <= 1'b1;
				if (room) begin
					cap_q <= cap_eff + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (accept && grow && room) begin
			pend_q <= ch;
		end
	end

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q <= CW'(NAME_MAX_LEN + 1))
		else $error("captured length beyond limit");

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= AW'(MAX_ENTRIES))
		else $error("entry count beyond limit");

	a_token_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_token_q == (cap_q != '0))
		else $error("token flag and captured length disagree");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_zero) |=> (at_list_start_q && !in_token_q && acc_q == '0))
		else $error("list end did not rearm the parser");

endmodule

>>> sv/dir_listing_tokenizer.sv
// Top level of the directory listing tokenizer.
// Holds the parser and a two-entry output buffer; depends on dlt_pkg and dlt_parser.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------------
//  input   | in_valid / in_ready  | ch
//  output  | out_valid / out_ready| char_valid entry_index char_pos char_value
//          |                      | entry_done entry_len entry_is_dir list_done entry_count
//
// One byte is taken per cycle while in_ready is high; each byte gives one registered result.
// The parse state updates in the cycle of the transfer, so throughput is set by the
// output buffer alone. A stalled output fills a skid entry, after which in_ready drops.
// Reset clears the parse state and empties both output entries.
module dir_listing_tokenizer #(
	parameter int MAX_ENTRIES  = dlt_pkg::DltMaxEntries,
	parameter int NAME_MAX_LEN = dlt_pkg::DltNameMaxLen
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dlt_pkg::CHAR_W-1:0]   ch,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         char_valid,
	output logic [dlt_pkg::IDX_W-1:0]    entry_index,
	output logic [dlt_pkg::POS_W-1:0]    char_pos,
	output logic [dlt_pkg::CHAR_W-1:0]   char_value,
	output logic                         entry_done,
	output logic [dlt_pkg::LEN_W-1:0]    entry_len,
	output logic                         entry_is_dir,
	output logic                         list_done,
	output logic [dlt_pkg::COUNT_W-1:0]  entry_count
);
	import dlt_pkg::*;

	logic        accept;
	dlt_result_t res;
	dlt_result_t out_q;
	dlt_result_t skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;

	assign in_ready = !skid_valid_q;
	assign accept = in_valid && in_ready;

	dlt_parser #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.NAME_MAX_LEN(NAME_MAX_LEN)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.ch    (ch),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign char_valid   = out_q.char_valid;
	assign entry_index  = out_q.entry_index;
	assign char_pos     = out_q.char_pos;
	assign char_value   = out_q.char_value;
	assign entry_done   = out_q.entry_done;
	assign entry_len    = out_q.entry_len;
	assign entry_is_dir = out_q.entry_is_dir;
	assign list_done    = out_q.list_done;
	assign entry_count  = out_q.entry_count;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready && accept))
		else $error("skid entry filled without a stalled transfer");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && out_valid_q && !out_ready) |=> skid_valid_q)
		else $error("result lost during output stall");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for dir_listing_tokenizer: directed rows, then random listings.
// A built-in tokenizer predicts each result that a directed row does not give. Depends on dlt_pkg and the block's RTL.
module tb_top;
	import dlt_pkg::*;

	localparam int MaxEntries  = DltMaxEntries;
	localparam int NameMax     = DltNameMaxLen;
	localparam int RandomItems = 600;
	localparam int DrainCycles = 20;
	localparam int CycleLimit  = 300000;

	typedef enum {LIST_PLAIN, LIST_LONG, LIST_FULL, LIST_PAREN, LIST_NOISE} list_kind_t;

	typedef struct {
		logic [CHAR_W-1:0] b;
		logic              typed;
		dlt_result_t       want;
	} step_row_t;

	localparam dlt_result_t NoResult     = '0;
	localparam dlt_result_t EmptyListEnd =
		{1'b0, 6'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b1, 7'd0};

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic [CHAR_W-1:0]   ch        = '0;
	logic                out_ready = 1'b0;
	logic                in_ready;
	logic                out_valid;
	logic                char_valid;
	logic [IDX_W-1:0]    entry_index;
	logic [POS_W-1:0]    char_pos;
	logic [CHAR_W-1:0]   char_value;
	logic                entry_done;
	logic [LEN_W-1:0]    entry_len;
	logic                entry_is_dir;
	logic                list_done;
	logic [COUNT_W-1:0]  entry_count;
	dlt_result_t         dut_res;

	// Tokenizer state mirrored by the predictor.
	logic                tk_at_start = 1'b1;
	logic                tk_rejected = 1'b0;
	logic                tk_in_token = 1'b0;
	int unsigned         tk_cap_len  = 0;
	logic [CHAR_W-1:0]   tk_pend     = '0;
	int unsigned         tk_entries  = 0;
	int unsigned         useful_items = 0;

	dlt_result_t         expected_q[$];
	dlt_result_t         predicted;
	dlt_result_t         want;
	logic                row_typed = 1'b0;
	dlt_result_t         row_want  = '0;

	int                  send_idle_pct  = 0;
	int                  recv_stall_pct = 0;
	int                  errors         = 0;
	int                  cycles         = 0;
	int                  sent_items     = 0;
	int                  results_checked = 0;
	int                  lists_seen     = 0;
	int                  names_seen     = 0;
	int                  dirs_seen      = 0;
	int                  longest_name   = 0;

	step_row_t dir_rows [23] = '{
		'{CH_NUL,    1'b1, EmptyListEnd},
		'{CH_LPAREN, 1'b1, NoResult},
		'{8'h78,     1'b1, NoResult},
		'{CH_NUL,    1'b1, EmptyListEnd},
		'{CH_SLASH,  1'b1, NoResult},
		'{CH_SPACE,  1'b1, NoResult},
		'{8'hFF,     1'b1, NoResult},
		'{CH_SLASH,  1'b1, {1'b1, 6'd0, 8'd0, 8'hFF, 1'b0, 8'd0, 1'b0, 1'b0, 7'd0}},
		'{CH_TAB,    1'b1, {1'b0, 6'd0, 8'd0, 8'd0, 1'b1, 8'd1, 1'b1, 1'b0, 7'd1}},
		'{8'h01,     1'b1, {1'b0, 6'd0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 7'd1}},
		'{CH_CR,     1'b1, {1'b1, 6'd1, 8'd0, 8'h01, 1'b1, 8'd1, 1'b0, 1'b0, 7'd2}},
		'{8'h61,     1'b0, NoResult},
		'{CH_LPAREN, 1'b0, NoResult},
		'{CH_LF,     1'b0, NoResult},
		'{8'h7F,     1'b0, NoResult},
		'{8'h80,     1'b0, NoResult},
		'{CH_SLASH,  1'b0, NoResult},
		'{CH_NUL,    1'b0, NoResult},
		'{CH_NUL,    1'b1, EmptyListEnd},
		'{CH_SPACE,  1'b0, NoResult},
		'{8'h7A,     1'b0, NoResult},
		'{CH_SPACE,  1'b0, NoResult},
		'{CH_NUL,    1'b0, NoResult}
	};

	dir_listing_tokenizer #(
		.MAX_ENTRIES (MaxEntries),
		.NAME_MAX_LEN(NameMax)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_valid  (char_valid),
		.entry_index (entry_index),
		.char_pos    (char_pos),
		.char_value  (char_value),
		.entry_done  (entry_done),
		.entry_len   (entry_len),
		.entry_is_dir(entry_is_dir),
		.list_done   (list_done),
		.entry_count (entry_count)
	);

	assign dut_res = {char_valid, entry_index, char_pos, char_value, entry_done,
		entry_len, entry_is_dir, list_done, entry_count};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic is_sep(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic void emit_name_byte(inout dlt_result_t r, input int unsigned pos,
		input logic [CHAR_W-1:0] v);
		r.char_valid  = 1'b1;
		r.entry_index = tk_entries[IDX_W-1:0];
		r.char_pos    = pos[POS_W-1:0];
		r.char_value  = v;
	endfunction

	// Closes the current token. The held byte is only now known to be a
	// name byte or the directory slash.
	function automatic void close_token(inout dlt_result_t r);
		int unsigned last;
		int unsigned len;
		logic        as_dir;
		last   = tk_cap_len - 1;
		as_dir = (tk_pend == CH_SLASH);
		len    = tk_cap_len - as_dir;
		if (!as_dir && last < NameMax)
			emit_name_byte(r, last, tk_pend);
		if (len > NameMax)
			len = NameMax;
		if (len > 0) begin
			r.entry_index  = tk_entries[IDX_W-1:0];
			r.entry_done   = 1'b1;
			r.entry_len    = len[LEN_W-1:0];
			r.entry_is_dir = as_dir;
			tk_entries++;
		end
		tk_in_token = 1'b0;
		tk_cap_len  = 0;
	endfunction

	function automatic dlt_result_t tokenize_step(input logic [CHAR_W-1:0] c);
		dlt_result_t r;
		logic        active;
		r = '0;
		if (tk_at_start) begin
			tk_at_start = 1'b0;
			if (c == CH_LPAREN)
				tk_rejected = 1'b1;
		end
		active = !tk_rejected && tk_entries < MaxEntries;
		if (active || c == CH_NUL)
			useful_items++;
		if (c == CH_NUL) begin
			if (active && tk_in_token)
				close_token(r);
			r.list_done   = 1'b1;
			r.entry_count = tk_rejected ? '0 : tk_entries[COUNT_W-1:0];
			tk_at_start = 1'b1;
			tk_rejected = 1'b0;
			tk_in_token = 1'b0;
			tk_cap_len  = 0;
			tk_entries  = 0;
		end else begin
			if (active) begin
				if (is_sep(c)) begin
					if (tk_in_token)
						close_token(r);
				end else begin
					if (!tk_in_token) begin
						tk_in_token = 1'b1;
						tk_cap_len  = 0;
					end
					if (tk_cap_len < NameMax + 1) begin
						if (tk_cap_len > 0)
							emit_name_byte(r, tk_cap_len - 1, tk_pend);
						tk_pend = c;
						tk_cap_len++;
					end
				end
			end
			r.entry_count = tk_rejected ? '0 : tk_entries[COUNT_W-1:0];
		end
		return r;
	endfunction

	task automatic log_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] exp);
		if (got !== exp)
			log_mismatch($sformatf("result %0d field %s got %0h expected %0h",
				results_checked, name, got, exp));
	endtask

	// Prediction happens on the input transfer and checking on the output
	// transfer, both in this one process, so the order is fixed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted = tokenize_step(ch);
				expected_q.push_back(row_typed ? row_want : predicted);
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					log_mismatch("result with nothing expected");
				end else begin
					want = expected_q.pop_front();
					check_field("char_valid", 32'(dut_res.char_valid),
						32'(want.char_valid));
					check_field("entry_index", 32'(dut_res.entry_index),
						32'(want.entry_index));
					check_field("char_pos", 32'(dut_res.char_pos),
						32'(want.char_pos));
					check_field("char_value", 32'(dut_res.char_value),
						32'(want.char_value));
					check_field("entry_done", 32'(dut_res.entry_done),
						32'(want.entry_done));
					check_field("entry_len", 32'(dut_res.entry_len),
						32'(want.entry_len));
					check_field("entry_is_dir", 32'(dut_res.entry_is_dir),
						32'(want.entry_is_dir));
					check_field("list_done", 32'(dut_res.list_done),
						32'(want.list_done));
					check_field("entry_count", 32'(dut_res.entry_count),
						32'(want.entry_count));
					if (want.list_done)
						lists_seen++;
					if (want.entry_done) begin
						names_seen++;
						dirs_seen += int'(want.entry_is_dir);
						if (int'(want.entry_len) > longest_name)
							longest_name = int'(want.entry_len);
					end
				end
				results_checked++;
			end
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("tb_top: timeout after %0d cycles, %0d results still due",
				cycles, expected_q.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// One byte transfer. A typed expectation, if any, is set up before valid
	// rises so that it is stable at the transfer edge.
	task automatic send_byte(input logic [CHAR_W-1:0] b, input logic typed = 1'b0,
		input dlt_result_t exp = '0);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			ch <= CHAR_W'($urandom);
			@(negedge clk);
		end
		row_typed = typed;
		row_want  = exp;
		in_valid <= 1'b1;
		ch <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_items++;
	endtask

	task automatic send_gap();
		int n;
		n = $urandom_range(1, 3);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: send_byte(CH_SPACE);
				1: send_byte(CH_TAB);
				2: send_byte(CH_CR);
				default: send_byte(CH_LF);
			endcase
		end
	endtask

	task automatic send_token(input int len, input logic as_dir);
		logic [CHAR_W-1:0] b;
		for (int i = 0; i < len; i++) begin
			do
				b = CHAR_W'($urandom_range(1, 255));
			while (is_sep(b));
			send_byte(b);
		end
		if (as_dir)
			send_byte(CH_SLASH);
	endtask

	task automatic send_list(input list_kind_t kind);
		int   ntok;
		int   len;
		logic as_dir;
		case ((sent_items / 150) % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
			default: begin send_idle_pct = 26; recv_stall_pct = 26; end
		endcase
		case (kind)
			LIST_LONG: begin
				case ($urandom_range(0, 4))
					0: len = NameMax - 1;
					1: len = NameMax;
					2: len = NameMax + 1;
					3: len = NameMax + 2;
					default: len = NameMax + 40;
				endcase
				send_token(len, $urandom_range(0, 1) == 1);
				if ($urandom_range(0, 1)) begin
					send_gap();
					send_token($urandom_range(1, 6), $urandom_range(0, 1) == 1);
				end
			end
			LIST_FULL: begin
				ntok = $urandom_range(MaxEntries, MaxEntries + 6);
				for (int t = 0; t < ntok; t++) begin
					send_token($urandom_range(1, 2), $urandom_range(0, 3) == 0);
					send_gap();
				end
			end
			LIST_NOISE: begin
				repeat ($urandom_range(4, 24))
					send_byte(CHAR_W'($urandom_range(0, 255)));
			end
			default: begin
				if (kind == LIST_PAREN)
					send_byte(CH_LPAREN);
				if ($urandom_range(0, 3) == 0)
					send_gap();
				ntok = $urandom_range(0, 8);
				for (int t = 0; t < ntok; t++) begin
					// A zero length with a slash gives the lone slash token.
					len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
					as_dir = (len == 0) || ($urandom_range(0, 3) == 0);
					send_token(len, as_dir);
					if (t < ntok - 1 || $urandom_range(0, 1))
						send_gap();
				end
			end
		endcase
		send_byte(CH_NUL);
	endtask

	initial begin
		int pick;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

		useful_items = 0;
		send_list(LIST_LONG);
		send_list(LIST_FULL);
		while (useful_items < RandomItems) begin
			pick = $urandom_range(0, 99);
			if (pick < 2)
				send_list(LIST_LONG);
			else if (pick < 5)
				send_list(LIST_FULL);
			else if (pick < 12)
				send_list(LIST_PAREN);
			else if (pick < 22)
				send_list(LIST_NOISE);
			else
				send_list(LIST_PLAIN);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("tb_top: %0d bytes in, %0d results checked over %0d lists",
			sent_items, results_checked, lists_seen);
		$display("tb_top: %0d names completed, %0d of them directories, longest %0d bytes",
			names_seen, dirs_seen, longest_name);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
